@@ rtl/ctw_pkg.sv @@
// Shared types, codes and character constants of the text console writer.
package ctw_pkg;

  // Request actions as they arrive on the input channel.
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_HEX   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Operations handed from the front end to the execution engine.
  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_NEWLINE = 3'd1;
  localparam logic [2:0] OP_HEX     = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h07;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;

  // A hex print puts "0x" and sixteen digits; this is the index of the last one.
  localparam logic [4:0] HEX_LAST_IDX = 5'd17;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [63:0] hex_value;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  char_code;
    logic [63:0] hex_value;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
    logic        read_ok;
  } cmd_t;

  // Uppercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

@@ rtl/ctw_fifo.sv @@
// Small synchronous queue built from registers.
module ctw_fifo
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 2)
  (input  logic             clk,
   input  logic             rst_n,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/ctw_front.sv @@
// Front end: accepts requests and turns them into engine operations.
module ctw_front
  import ctw_pkg::*;
  #(parameter int COLS = 80,
    parameter int ROWS = 25)
  (input  in_item_t in_data,
   input  logic     in_push,
   output logic     in_full,
   input  logic     init_busy,
   input  logic     cmd_full,
   output logic     cmd_push,
   output cmd_t     cmd);

  assign in_full  = cmd_full | init_busy;
  assign cmd_push = in_push & ~in_full;

  always_comb begin
    cmd.char_code = in_data.char_code;
    cmd.hex_value = in_data.hex_value;
    cmd.read_row  = in_data.read_row;
    cmd.read_col  = in_data.read_col;
    cmd.read_ok   = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLS);
    unique case (in_data.action)
      ACT_PUT: begin
        cmd.op = (in_data.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      ACT_HEX:   cmd.op = OP_HEX;
      ACT_CLEAR: cmd.op = OP_CLEAR;
      ACT_READ:  cmd.op = OP_READ;
      default:   cmd.op = OP_READ;
    endcase
  end

endmodule

@@ rtl/ctw_back.sv @@
// Execution engine: owns the screen memory, the cursor and the text color.
module ctw_back
  import ctw_pkg::*;
  #(parameter int COLS = 80,
    parameter int ROWS = 25)
  (input  logic      clk,
   input  logic      rst_n,
   input  logic      cfg_wr_en,
   input  logic [7:0] cfg_wr_data,
   input  logic      cmd_empty,
   input  cmd_t      cmd,
   output logic      cmd_pop,
   input  logic      res_full,
   output logic      res_push,
   output out_item_t res,
   output logic      init_busy);

  localparam int CELLS = ROWS * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_PUT   = 3'd3;
  localparam logic [2:0] ST_NL    = 3'd4;
  localparam logic [2:0] ST_NEXT  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [1:0] KIND_INIT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_r;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [63:0] hex_r, hex_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        cell_ok_r, cell_ok_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]  color_r;
  logic [AW-1:0] wa_r, wa_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  logic [31:0] sweep_rd_addr;
  logic [31:0] row_ext, col_ext;
  logic [7:0]  fill_color;
  logic        after_nl_done;

  assign init_busy = (kind_r == KIND_INIT) &&
                     ((state_r == ST_PRIME) || (state_r == ST_SWEEP));
  assign fill_color = (kind_r == KIND_INIT) ? RESET_COLOR : color_r;
  // A bare newline finishes here; a wrapped character still has to be written.
  assign after_nl_done = (op_r == OP_NEWLINE);
  assign sweep_rd_addr = 32'(wa_r) + 32'(COLS) + ((state_r == ST_SWEEP) ? 32'd1 : 32'd0);

  assign row_ext = 32'(row_r);
  assign col_ext = 32'(col_r);

  always_comb begin
    res.cell_char  = cell_ok_r ? rdata_r[15:8] : 8'h00;
    res.cell_color = cell_ok_r ? rdata_r[7:0] : 8'h00;
    res.cursor_row = row_ext[4:0];
    res.cursor_col = col_ext[6:0];
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    hex_nxt     = hex_r;
    idx_nxt     = idx_r;
    cell_ok_nxt = cell_ok_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    wa_nxt      = wa_r;
    mem_we      = 1'b0;
    mem_wa      = wa_r;
    mem_wd      = {BLANK_CODE, fill_color};
    mem_re      = 1'b0;
    mem_ra      = AW'(sweep_rd_addr);
    cmd_pop     = 1'b0;
    res_push    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop     = 1'b1;
          op_nxt      = cmd.op;
          ch_nxt      = cmd.char_code;
          cell_ok_nxt = 1'b0;
          unique case (cmd.op)
            OP_PUT:     state_nxt = ST_PUT;
            OP_NEWLINE: state_nxt = ST_NL;
            OP_HEX: begin
              ch_nxt    = CHAR_ZERO;
              idx_nxt   = '0;
              hex_nxt   = cmd.hex_value;
              state_nxt = ST_PUT;
            end
            OP_CLEAR: begin
              kind_nxt  = KIND_CLEAR;
              wa_nxt    = '0;
              state_nxt = ST_PRIME;
            end
            default: begin
              // Cell read; the data lands in rdata_r by the result cycle.
              cell_ok_nxt = cmd.read_ok;
              mem_re      = cmd.read_ok;
              mem_ra      = AW'(32'(cmd.read_row) * COLS + 32'(cmd.read_col));
              state_nxt   = ST_DONE;
            end
          endcase
        end
      end

      ST_PRIME: begin
        mem_re    = (sweep_rd_addr < 32'(CELLS));
        state_nxt = ST_SWEEP;
      end

      ST_SWEEP: begin
        mem_we = 1'b1;
        if (kind_r == KIND_SCROLL && 32'(wa_r) < CELLS - COLS) begin
          mem_wd = rdata_r;
        end
        mem_re = (sweep_rd_addr < 32'(CELLS));
        if (32'(wa_r) == CELLS - 1) begin
          unique case (kind_r)
            KIND_INIT: state_nxt = ST_IDLE;
            KIND_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = ST_DONE;
            end
            default: state_nxt = after_nl_done ? ST_DONE : ST_PUT;
          endcase
        end else begin
          wa_nxt = wa_r + AW'(1);
        end
      end

      ST_PUT: begin
        if (col_ext >= COLS) begin
          state_nxt = ST_NL;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = AW'(row_ext * COLS + col_ext);
          mem_wd    = {ch_r, color_r};
          col_nxt   = col_r + CW'(1);
          state_nxt = ST_NEXT;
        end
      end

      ST_NL: begin
        col_nxt = '0;
        if (row_ext < ROWS - 1) begin
          row_nxt   = row_r + RW'(1);
          state_nxt = after_nl_done ? ST_DONE : ST_PUT;
        end else begin
          kind_nxt  = KIND_SCROLL;
          wa_nxt    = '0;
          state_nxt = ST_PRIME;
        end
      end

      ST_NEXT: begin
        if (op_r == OP_HEX && idx_r != HEX_LAST_IDX) begin
          idx_nxt = idx_r + 5'd1;
          if (idx_r == '0) begin
            ch_nxt = CHAR_X;
          end else begin
            ch_nxt  = hex_char(hex_r[63:60]);
            hex_nxt = {hex_r[59:0], 4'h0};
          end
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PRIME;
      kind_r  <= KIND_INIT;
      wa_r    <= '0;
      row_r   <= '0;
      col_r   <= '0;
      color_r <= RESET_COLOR;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      wa_r    <= wa_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ch_r      <= ch_nxt;
    hex_r     <= hex_nxt;
    idx_r     <= idx_nxt;
    cell_ok_r <= cell_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

endmodule

@@ rtl/text_console_writer.sv @@
// Text console writer: ROWS x COLS character screen with cursor, scroll and hex print.
// Each request, a character, newline, hex print, clear or read, ends with one result item.
// A hex print writes "0x" and sixteen digits; a character past the last column wraps to the next line.
// A newline on the last row scrolls the screen up, a clear blanks it; one request is worked at a time.
// After reset the memory is blanked while in_full stays high.
// Reset is synchronous and active low; the text color returns to 0x07.
module text_console_writer
  import ctw_pkg::*;
  #(parameter int COLS = 80,
    parameter int ROWS = 25)
  (input  logic      clk,
   input  logic      rst_n,
   input  logic      in_push,
   input  in_item_t  in_data,
   output logic      in_full,
   input  logic      out_pop,
   output out_item_t out_data,
   output logic      out_empty,
   input  logic      cfg_wr_en,
   input  logic [7:0] cfg_wr_data);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(out_item_t);

  cmd_t       cmd_in, cmd_out;
  logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_rdata;
  out_item_t  res;
  logic       res_push, res_full;
  logic [RES_W-1:0] res_rdata;
  logic       init_busy;

  ctw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
    .in_data  (in_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .init_busy(init_busy),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  ctw_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_rdata),
    .empty(cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_rdata);

  ctw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res),
    .init_busy  (init_busy)
  );

  ctw_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_rdata),
    .empty(out_empty)
  );

  assign out_data = out_item_t'(res_rdata);

endmodule

@@ rtl/ctw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
module ctw_checker
  import ctw_pkg::*;
  #(parameter int COLS = 80,
    parameter int ROWS = 25)
  (input logic      clk,
   input logic      rst_n,
   input logic      in_full,
   input logic      out_empty,
   input logic      out_pop,
   input out_item_t out_data);

  // The screen is blanked after reset, so no request is taken right away.
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("in_full low right after reset");

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (32'(out_data.cursor_col) <= COLS))
    else $error("cursor column beyond wrap position");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (32'(out_data.cursor_row) < ROWS))
    else $error("cursor row beyond last row");

endmodule

bind text_console_writer ctw_checker #(.COLS(COLS), .ROWS(ROWS)) u_ctw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_data (out_data)
);
